FILE: design/efrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efrb_pkg;

	localparam int MODE_W   = 3;
	localparam int IDX_W    = 5;
	localparam int BITS_W   = 16;
	localparam int TASK_W   = 8;
	localparam int STATUS_W = 2;
	localparam int REGOUT_W = 4;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 40;

	typedef enum logic [MODE_W-1:0] {
		MODE_ASSIGN   = 3'd0,
		MODE_FREE     = 3'd1,
		MODE_SETWAIT  = 3'd2,
		MODE_SET      = 3'd3,
		MODE_CLEAR    = 3'd4,
		MODE_CHECK    = 3'd5,
		MODE_GET      = 3'd6,
		MODE_REASSIGN = 3'd7
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_NO_ROOM = 2'd1,
		STATUS_BAD_IDX = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic read;
		logic exec;
	} efrb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} efrb_stat_t;

endpackage

`default_nettype wire

FILE: design/event_flag_register_bank_top.sv
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tuser: mode; s_tdata: index, wait type, flags, task
// m_*      out  m_tvalid/m_tready  m_tdata: status, index, flags, pending, wake, tasks
//
// A request word passes through accept, entry RAM read, and execute with write-back.
// The entry RAM is read through a single registered read ahead of its read-modify-write.
// Reset clears the use, pending and written bits at once; no clearing pass.
// The result sits in an output register, so the next word is accepted while it waits;
// a stalled output holds the following word in its execute cycle.
`timescale 1ns / 1ps
`default_nettype none

module event_flag_register_bank_top
	import efrb_pkg::*;
#(
	parameter int NUM_REGS   = 16,
	parameter int FLAG_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,  // reg_index, wait_all, flag_bits, task_id, zero pad
	input  wire logic [MODE_W-1:0] s_tuser,  // mode
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata   // status, reg_out, flags_out, pending_out, wake,
	                                         // wake_task, prev_task
);

	efrb_cmd_t  cmd;
	efrb_stat_t st;

	logic [STATUS_W-1:0] status;
	logic [REGOUT_W-1:0] reg_out;
	logic [BITS_W-1:0]   flags_out;
	logic                pending_out;
	logic                wake;
	logic [TASK_W-1:0]   wake_task;
	logic [TASK_W-1:0]   prev_task;

	efrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	efrb_dp #(
		.NUM_REGS   (NUM_REGS),
		.FLAG_WIDTH (FLAG_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.mode        (s_tuser),
		.reg_index   (s_tdata[4:0]),
		.wait_all    (s_tdata[5]),
		.flag_bits   (s_tdata[21:6]),
		.task_id     (s_tdata[29:22]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.status      (status),
		.reg_out     (reg_out),
		.flags_out   (flags_out),
		.pending_out (pending_out),
		.wake        (wake),
		.wake_task   (wake_task),
		.prev_task   (prev_task)
	);

	assign m_tdata = {prev_task, wake_task, wake, pending_out, flags_out, reg_out, status};

endmodule

`default_nettype wire

FILE: design/efrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module efrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic                   re,
	input  wire logic [AW-1:0]          raddr,
	output logic      [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/efrb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module efrb_ctrl
	import efrb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire efrb_stat_t st,
	output efrb_cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_READ;
						ready_q <= 1'b0;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					// hold until the output register can take the result
					if (st.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign s_tready = ready_q;

	always_comb begin
		cmd.load = s_tvalid & ready_q;
		cmd.read = (state_q == ST_READ);
		cmd.exec = (state_q == ST_EXEC) & st.out_free;
	end

endmodule

`default_nettype wire

FILE: design/efrb_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module efrb_dp
	import efrb_pkg::*;
#(
	parameter int NUM_REGS   = 16,
	parameter int FLAG_WIDTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire efrb_cmd_t           cmd,
	output efrb_stat_t               st,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [IDX_W-1:0]    reg_index,
	input  wire logic                wait_all,
	input  wire logic [BITS_W-1:0]   flag_bits,
	input  wire logic [TASK_W-1:0]   task_id,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic [REGOUT_W-1:0]      reg_out,
	output logic [BITS_W-1:0]        flags_out,
	output logic                     pending_out,
	output logic                     wake,
	output logic [TASK_W-1:0]        wake_task,
	output logic [TASK_W-1:0]        prev_task
);

	localparam int AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int WORD_W = 1 + 2 * FLAG_WIDTH + TASK_W;

	// entry word layout: {need_all, wait_mask, flag_word, owner}
	typedef struct packed {
		logic                  need_all;
		logic [FLAG_WIDTH-1:0] mask;
		logic [FLAG_WIDTH-1:0] flags;
		logic [TASK_W-1:0]     owner;
	} entry_t;

	mode_t              mode_q;
	logic [IDX_W-1:0]   idx_q;
	logic               wt_q;
	logic [BITS_W-1:0]  bits_q;
	logic [TASK_W-1:0]  task_q;

	logic [NUM_REGS-1:0] in_use_q;
	logic [NUM_REGS-1:0] pending_q;
	logic [NUM_REGS-1:0] written_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [REGOUT_W-1:0] reg_out_q;
	logic [BITS_W-1:0]   flags_out_q;
	logic                pend_out_q;
	logic                wake_q;
	logic [TASK_W-1:0]   wake_task_q;
	logic [TASK_W-1:0]   prev_task_q;

	logic                  free_found;
	logic [AW-1:0]         free_idx;
	logic                  idx_ok;
	logic                  idx_empty;
	logic [AW-1:0]         sel;
	logic [WORD_W-1:0]     rdata;
	entry_t                cur;
	entry_t                nxt;
	logic [FLAG_WIDTH-1:0] bits;
	logic [FLAG_WIDTH-1:0] new_flags;
	logic [FLAG_WIDTH-1:0] ready_bits;
	logic                  hit;
	logic                  used;
	logic                  ram_we;
	logic                  use_wr;
	logic                  use_val;
	logic                  pend_wr;
	logic                  pend_val;

	logic [STATUS_W-1:0] r_status;
	logic [REGOUT_W-1:0] r_reg_out;
	logic [BITS_W-1:0]   r_flags;
	logic                r_pend;
	logic                r_wake;
	logic [TASK_W-1:0]   r_wake_task;
	logic [TASK_W-1:0]   r_prev_task;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_t'(mode);
			idx_q  <= reg_index;
			wt_q   <= wait_all;
			bits_q <= flag_bits;
			task_q <= task_id;
		end
	end

	// lowest free entry
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = NUM_REGS - 1; k >= 0; k--) begin
			if (!in_use_q[k]) begin
				free_found = 1'b1;
				free_idx   = AW'(k);
			end
		end
	end

	assign idx_ok    = 32'(idx_q) < NUM_REGS;
	assign idx_empty = 32'(idx_q) == NUM_REGS;
	assign sel       = (mode_q == MODE_ASSIGN) ? free_idx : (idx_ok ? AW'(idx_q) : '0);
	assign used      = idx_ok & in_use_q[sel];
	assign bits      = FLAG_WIDTH'(bits_q);

	efrb_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_REGS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sel),
		.wdata (nxt),
		.re    (cmd.read),
		.raddr (sel),
		.rdata (rdata)
	);

	// an entry never written reads as its reset value
	assign cur = written_q[sel] ? entry_t'(rdata) : '0;

	always_comb begin
		nxt         = cur;
		ram_we      = 1'b0;
		use_wr      = 1'b0;
		use_val     = 1'b0;
		pend_wr     = 1'b0;
		pend_val    = 1'b0;
		new_flags   = cur.flags;
		ready_bits  = '0;
		hit         = 1'b0;
		r_status    = STATUS_OK;
		r_reg_out   = '0;
		r_flags     = '0;
		r_pend      = 1'b0;
		r_wake      = 1'b0;
		r_wake_task = '0;
		r_prev_task = '0;
		unique case (mode_q)
			MODE_ASSIGN: begin
				if (free_found) begin
					r_reg_out = REGOUT_W'(free_idx);
					nxt.flags = '0;
					nxt.owner = task_q;
					ram_we    = 1'b1;
					use_wr    = 1'b1;
					use_val   = 1'b1;
					pend_wr   = 1'b1;
				end else begin
					r_status = STATUS_NO_ROOM;
				end
			end
			MODE_CHECK: begin
				if (idx_empty) begin
					r_status = STATUS_OK;
				end else if (!idx_ok) begin
					r_status = STATUS_BAD_IDX;
				end else begin
					r_flags = BITS_W'(cur.flags);
					r_pend  = pending_q[sel];
					if (pending_q[sel]) begin
						nxt.flags = '0;
						ram_we    = 1'b1;
						pend_wr   = 1'b1;
					end
				end
			end
			MODE_FREE, MODE_REASSIGN, MODE_SETWAIT, MODE_GET, MODE_SET, MODE_CLEAR: begin
				if (!used) begin
					r_status = STATUS_BAD_IDX;
				end else begin
					priority case (mode_q)
						MODE_FREE: begin
							r_prev_task = cur.owner;
							use_wr      = 1'b1;
						end
						MODE_REASSIGN: begin
							r_prev_task = cur.owner;
							nxt.flags   = '0;
							nxt.owner   = task_q;
							ram_we      = 1'b1;
							pend_wr     = 1'b1;
						end
						MODE_SETWAIT: begin
							nxt.flags    = '0;
							nxt.need_all = wt_q;
							nxt.mask     = bits;
							ram_we       = 1'b1;
							pend_wr      = 1'b1;
						end
						MODE_GET: begin
							r_flags = BITS_W'(cur.flags);
						end
						default: begin
							new_flags  = (mode_q == MODE_SET) ? (cur.flags | bits)
							                                  : (cur.flags & ~bits);
							ready_bits = cur.mask & new_flags;
							hit        = cur.need_all ? (ready_bits == cur.mask)
							                          : (ready_bits != '0);
							nxt.flags  = new_flags;
							ram_we     = 1'b1;
							if (hit) begin
								pend_wr     = 1'b1;
								pend_val    = 1'b1;
								r_wake      = 1'b1;
								r_wake_task = cur.owner;
							end
						end
					endcase
				end
			end
			default: begin
				r_status = STATUS_BAD_IDX;
			end
		endcase
		ram_we = ram_we & cmd.exec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			pending_q <= '0;
			written_q <= '0;
		end else if (cmd.exec) begin
			if (use_wr) begin
				in_use_q[sel] <= use_val;
			end
			if (pend_wr) begin
				pending_q[sel] <= pend_val;
			end
			if (ram_we) begin
				written_q[sel] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q    <= r_status;
			reg_out_q   <= r_reg_out;
			flags_out_q <= r_flags;
			pend_out_q  <= r_pend;
			wake_q      <= r_wake;
			wake_task_q <= r_wake_task;
			prev_task_q <= r_prev_task;
		end
	end

	assign st.out_free = ~out_valid_q | out_ready;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign reg_out     = reg_out_q;
	assign flags_out   = flags_out_q;
	assign pending_out = pend_out_q;
	assign wake        = wake_q;
	assign wake_task   = wake_task_q;
	assign prev_task   = prev_task_q;

endmodule

`default_nettype wire
